@@ rtl/b32d_pkg.sv @@
package b32d_pkg;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       done_res;
    logic [1:0] status;
  } out_beat_t;

  localparam logic [1:0] StatusOk      = 2'd0;
  localparam logic [1:0] StatusBadChar = 2'd1;
  localparam logic [1:0] StatusBadLen  = 2'd2;

  // char count mod 8 that cannot end a string: 1, 3, 6
  localparam logic [7:0] BadTailMask = 8'b0100_1010;

  localparam logic [7:0] DigitBase = 8'd26;

  typedef struct packed {
    logic       ok;
    logic [4:0] value;
  } sym_t;

  function automatic sym_t sym_decode(input logic [7:0] c);
    sym_t s;
    s = '{ok: 1'b0, value: 5'd0};
    if (c >= 8'h41 && c <= 8'h5A) begin
      s.ok    = 1'b1;
      s.value = 5'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      s.ok    = 1'b1;
      s.value = 5'(c - 8'h61);
    end else if (c >= 8'h32 && c <= 8'h37) begin
      s.ok    = 1'b1;
      s.value = 5'(c - 8'h32 + DigitBase);
    end
    return s;
  endfunction

endpackage

@@ rtl/base32_stream_decoder_unit.sv @@
// Channel | Dir | Handshake           | Payload
// in      | in  | in_valid/in_ready   | in_data  (char_code, last_char)
// out     | out | out_valid/out_ready | out_data (data_byte, byte_valid, done_res, status)
//
// One beat in gives exactly one beat out, registered in the output or skid register.
// Sustained rate is one character per cycle while in_ready holds; the decode is a range
// compare plus a shift of the 12-bit bit accumulator, all combinational.
// A two-entry output stage (output register plus skid register) lets a beat
// be taken while the previous result waits; in_ready drops only when both hold.
// rst is synchronous, active high; it clears the decode state and both valids.
module base32_stream_decoder_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  b32d_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output b32d_pkg::out_beat_t out_data
);
  import b32d_pkg::*;

  // decode state
  logic [11:0] bit_accumulator;
  logic [2:0]  pending_bits;
  logic [2:0]  char_phase;
  logic        bad_char_seen;

  logic [11:0] bit_accumulator_next;
  logic [2:0]  pending_bits_next;
  logic [2:0]  char_phase_next;
  logic        bad_char_seen_next;

  // output stage
  out_beat_t skid_data;
  logic      skid_valid;

  out_beat_t res;
  sym_t      sym;
  logic      bad_now;
  logic [3:0] p_sum;
  logic [11:0] acc_shift;
  logic      in_fire;

  assign in_ready = !skid_valid;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    sym       = sym_decode(in_data.char_code);
    bad_now   = bad_char_seen || !sym.ok;
    p_sum     = {1'b0, pending_bits} + 4'd5;
    acc_shift = {bit_accumulator[6:0], sym.value};

    bit_accumulator_next = bit_accumulator;
    pending_bits_next    = pending_bits;
    res                  = '0;

    if (!bad_now) begin
      bit_accumulator_next = acc_shift;
      pending_bits_next    = p_sum[2:0];
      // 8..12 bits pending: oldest 8 leave, low 3 bits of the sum give the rest
      if (p_sum[3]) begin
        res.data_byte  = 8'(acc_shift >> p_sum[2:0]);
        res.byte_valid = 1'b1;
      end
    end

    char_phase_next    = char_phase + 3'd1;
    bad_char_seen_next = bad_now;
    res.done_res       = in_data.last_char;

    if (in_data.last_char) begin
      if (bad_now) begin
        res.status = StatusBadChar;
      end else if (BadTailMask[char_phase_next]) begin
        res.status = StatusBadLen;
      end else begin
        res.status = StatusOk;
      end
      // string ends: back to reset state, tail bits dropped
      bit_accumulator_next = '0;
      pending_bits_next    = '0;
      char_phase_next      = '0;
      bad_char_seen_next   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_accumulator <= '0;
      pending_bits    <= '0;
      char_phase      <= '0;
      bad_char_seen   <= 1'b0;
    end else if (in_fire) begin
      bit_accumulator <= bit_accumulator_next;
      pending_bits    <= pending_bits_next;
      char_phase      <= char_phase_next;
      bad_char_seen   <= bad_char_seen_next;
    end
  end

  // output register with skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid  <= in_fire;
      end
    end else if (in_fire) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (in_fire) begin
        out_data <= res;
      end
    end else if (in_fire) begin
      skid_data <= res;
    end
  end

endmodule

@@ rtl/b32d_check.sv @@
module b32d_check (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input b32d_pkg::in_beat_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input b32d_pkg::out_beat_t out_data
);
  import b32d_pkg::*;

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("in beat dropped or changed while stalled");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("out beat dropped or changed while stalled");

  a_status_only_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.done_res |-> out_data.status == StatusOk)
    else $error("status set on a beat that is not the last");

  a_fail_no_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != StatusOk |-> !out_data.byte_valid)
    else $error("byte emitted on a failed final character");

  a_zero_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.byte_valid |-> out_data.data_byte == 8'd0)
    else $error("data_byte nonzero without byte_valid");

endmodule

bind base32_stream_decoder_unit b32d_check u_b32d_check (.*);
